// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// ante at one edge implies cons at the same edge
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication broken");

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication broken");

`endif

// ----- src/tbp_pkg.sv -----
// Package: types, constants and response table of the tablet packet decoder.
`default_nettype none
package tbp_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned PRES_W    = 13;
  localparam int unsigned BTN_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GAIN_W    = 16;

  localparam int unsigned Q_DEPTH   = 2;

  localparam int unsigned PKT_STORE = 6;
  localparam int unsigned POS_W     = 3;
  localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST = 3'd6;

  localparam int unsigned ROM_SIZE  = 66;
  localparam int unsigned ROM_IDX_W = 7;
  localparam logic signed [8:0] ROM_BIAS   = 9'sd30;
  localparam logic signed [8:0] NEG_OFFSET = 9'sd127;
  localparam logic signed [8:0] ROM_TOP    = 9'sd65;

  localparam logic [PRES_W-1:0] FULL_Q12      = 13'd4096;
  localparam logic [CFG_W-1:0]  JUMP_LIM_RST  = 16'd50;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_LIMIT    = 2'd0,
    CFG_PRESSURE_GAIN = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;
  } cfg_wr_t;

  // one classified event handed from front to back
  typedef struct packed {
    logic               report_only;  // timeout or not-ready packet
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pen;          // pen (1) or puck (0)
    logic [BTN_W-1:0]   puck_btn;
    logic [PRES_W-1:0]  rom_val;
  } q_entry_t;

  // Q12 pressure response curve
  localparam logic [PRES_W-1:0] RESP_ROM [ROM_SIZE] = '{
    13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
    13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
    13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd41, 13'd82,
    13'd123, 13'd164, 13'd205, 13'd246, 13'd287, 13'd328, 13'd369, 13'd410,
    13'd461, 13'd512, 13'd563, 13'd614, 13'd684, 13'd754, 13'd819,
    13'd889, 13'd958, 13'd1024, 13'd1126, 13'd1229,
    13'd1298, 13'd1368, 13'd1434, 13'd1536, 13'd1638,
    13'd1843, 13'd2048, 13'd2253, 13'd2662, 13'd3072,
    13'd3277, 13'd3482, 13'd3686, 13'd3891, 13'd4096, 13'd4096
  };

endpackage
`default_nettype wire

// ----- src/tbp_in_if.sv -----
// Input channel: serial byte or timeout event.
`default_nettype none
interface tbp_in_if import tbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface
`default_nettype wire

// ----- src/tbp_out_if.sv -----
// Result channel: decoded tablet sample.
`default_nettype none
interface tbp_out_if import tbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [PRES_W-1:0]  pressure;
  logic [BTN_W-1:0]   button;
  logic               valid_res;

  modport source (output valid, pos_x, pos_y, pressure, button, valid_res, input ready);
  modport sink   (input valid, pos_x, pos_y, pressure, button, valid_res, output ready);
endinterface
`default_nettype wire

// ----- src/tbp_front.sv -----
// Front end: sync hunt, packet assembly and field extraction.
`default_nettype none
module tbp_front import tbp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tbp_in_if.sink      in_ch,
  input  wire logic   q_full,
  output logic        q_push,
  output q_entry_t    q_data
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] bytes_r [PKT_STORE];
  logic              fire;
  logic              store_en;
  logic [BYTE_W-1:0] b0;
  logic [BYTE_W-1:0] rx;
  logic signed [8:0] idx_s;
  logic [ROM_IDX_W-1:0] rom_idx;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;
  assign b0          = bytes_r[0];

  always_comb begin
    pos_nxt  = pos_r;
    q_push   = 1'b0;
    store_en = 1'b0;
    if (fire) begin
      if (in_ch.func) begin
        pos_nxt = POS_HUNT;
        q_push  = 1'b1;
      end else begin
        case (pos_r)
          POS_HUNT: begin
            if (rx[BYTE_W-1]) begin
              pos_nxt  = 3'd1;
              store_en = 1'b1;
            end
          end
          POS_LAST: begin
            pos_nxt = POS_HUNT;
            q_push  = 1'b1;
          end
          default: begin
            pos_nxt  = pos_r + 3'd1;
            store_en = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      bytes_r[pos_r] <= rx;
    end
  end

  // pressure code: 7-bit value, bit 6 marks it negative (offset by 127)
  always_comb begin
    idx_s = $signed({2'b00, rx[6:0]}) + ROM_BIAS;
    if (rx[6]) begin
      idx_s = idx_s - NEG_OFFSET;
    end
    if (idx_s < 0) begin
      rom_idx = '0;
    end else if (idx_s > ROM_TOP) begin
      rom_idx = ROM_IDX_W'(ROM_TOP);
    end else begin
      rom_idx = idx_s[ROM_IDX_W-1:0];
    end
  end

  always_comb begin
    q_data.report_only = in_ch.func || !b0[6];
    q_data.x = {8'h00, bytes_r[2]} | {1'b0, bytes_r[1], 7'h00} | {b0[1:0], 14'h0000};
    q_data.y = {8'h00, bytes_r[5]} | {1'b0, bytes_r[4], 7'h00} | {bytes_r[3][1:0], 14'h0000};
    q_data.pen      = b0[5];
    q_data.puck_btn = rx[BTN_W-1:0];
    q_data.rom_val  = RESP_ROM[rom_idx];
  end

endmodule
`default_nettype wire

// ----- src/tbp_queue.sv -----
// Small FIFO between the front and back ends.
`default_nettype none
module tbp_queue import tbp_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wr_data,
  input  wire logic     pop,
  output q_entry_t      rd_data,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/tbp_back.sv -----
// Back end: pressure scaling, jump filter, last-point tracking, output register.
`default_nettype none
module tbp_back import tbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_wr_t  cfg,
  input  wire q_entry_t q_data,
  input  wire logic     q_empty,
  output logic          q_pop,
  tbp_out_if.source     out_ch
);

  logic [CFG_W-1:0]   jump_lim_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [COORD_W-1:0] last_x_r, last_y_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [PRES_W-1:0]  out_pres_r;
  logic [BTN_W-1:0]   out_btn_r;
  logic               out_vres_r;

  logic [28:0]        prod;
  logic [16:0]        scaled;
  logic [PRES_W-1:0]  pres;
  logic [BTN_W-1:0]   btn;
  logic [COORD_W-1:0] dx, dy;
  logic               jump;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    prod   = 29'(q_data.rom_val) * 29'(gain_r) + 29'd2048;
    scaled = prod[28:12];
    if (q_data.pen) begin
      pres = (scaled > 17'(FULL_Q12)) ? FULL_Q12 : scaled[PRES_W-1:0];
      btn  = {2'b00, (pres != '0)};
    end else begin
      btn  = q_data.puck_btn;
      pres = (btn != '0) ? FULL_Q12 : '0;
    end
  end

  always_comb begin
    dx   = (q_data.x > last_x_r) ? q_data.x - last_x_r : last_x_r - q_data.x;
    dy   = (q_data.y > last_y_r) ? q_data.y - last_y_r : last_y_r - q_data.y;
    jump = (dx > jump_lim_r) || (dy > jump_lim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_lim_r <= JUMP_LIM_RST;
      gain_r     <= GAIN_RST;
    end else if (cfg.we) begin
      case (cfg_idx_t'(cfg.index))
        CFG_JUMP_LIMIT:    jump_lim_r <= cfg.wdata;
        CFG_PRESSURE_GAIN: gain_r     <= cfg.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        if (!q_data.report_only) begin
          last_x_r <= q_data.x;
          last_y_r <= q_data.y;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.report_only || jump) begin
        out_x_r    <= last_x_r;
        out_y_r    <= last_y_r;
        out_pres_r <= '0;
        out_btn_r  <= '0;
        out_vres_r <= 1'b0;
      end else begin
        out_x_r    <= q_data.x;
        out_y_r    <= q_data.y;
        out_pres_r <= pres;
        out_btn_r  <= btn;
        out_vres_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x     = out_x_r;
  assign out_ch.pos_y     = out_y_r;
  assign out_ch.pressure  = out_pres_r;
  assign out_ch.button    = out_btn_r;
  assign out_ch.valid_res = out_vres_r;

endmodule
`default_nettype wire

// ----- src/tablet_binary_packet_decoder_unit.sv -----
// Top level of the tablet binary packet decoder.
// Takes one serial byte or timeout event per cycle while in ready is high. The
// front end hunts for a sync byte, gathers the 7-byte packet and looks up the
// pressure response; a queue of QUEUE_DEPTH entries hands each finished packet
// or timeout to the back end, which applies the gain, the jump filter and the
// last-point memory and holds the sample in an output register. Sustained rate
// is one item per cycle while the output is not stalled; a result is registered
// first in the queue and then in the output register before it is valid, and
// waits in the queue while the output is stalled. in ready drops only when the
// queue fills behind a stalled output. There is no clearing pass after reset.
// Write configuration only while idle.
`default_nettype none
`include "assert_macros.svh"
module tablet_binary_packet_decoder_unit import tbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  tbp_in_if.sink                    in_ch,
  tbp_out_if.source                 out_ch
);

  cfg_wr_t  cfg;
  q_entry_t push_data, pop_data;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  tbp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  tbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (pop_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  tbp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (pop_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `ASSERT_NEVER(a_q_full_and_empty, q_full && q_empty)
  `ASSERT_IMPL(a_pop_needs_entry, q_pop, !q_empty)
  `ASSERT_NEXT(a_timeout_gives_result, in_ch.valid && in_ch.ready && in_ch.func, !q_empty || out_ch.valid)

endmodule
`default_nettype wire
